FILE: rtl/hcbd_pkg.sv
package hcbd_pkg;

	localparam int unsigned SIZE_BITS_DEF = 24;
	localparam int unsigned LIMIT_W = 24;
	localparam int unsigned COUNT_W = 24;

	localparam logic [LIMIT_W-1:0] BODY_LIMIT_RST = 24'd524288;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_START = 1'b1;

	localparam logic [1:0] TRAIL_LEN = 2'd2;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_SIZE = 3'd0,
		PH_SEEK = 3'd1,
		PH_DATA = 3'd2,
		PH_TRAIL = 3'd3,
		PH_DONE = 3'd4,
		PH_FAULT = 3'd5
	} phase_t;

	typedef struct packed {
		logic op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} res_t;

endpackage

FILE: rtl/hcbd_in_reg.sv
module hcbd_in_reg (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hcbd_pkg::item_t item_in,
	input logic take,
	output logic valid_s1,
	output hcbd_pkg::item_t item_s1
);

	logic load;

	assign in_ready = !valid_s1 || take;
	assign load = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

FILE: rtl/hcbd_core.sv
module hcbd_core #(
	parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input hcbd_pkg::item_t item,
	input logic [hcbd_pkg::LIMIT_W-1:0] body_limit,
	output logic emit,
	output hcbd_pkg::res_t res
);

	hcbd_pkg::phase_t phase_q, phase_d;
	logic [SIZE_BITS-1:0] chunk_q, chunk_d;
	logic seen_cr_q, seen_cr_d;
	logic [1:0] trail_q, trail_d;
	logic [hcbd_pkg::COUNT_W-1:0] count_q, count_d;

	logic [4:0] hex;
	logic is_hex;
	logic [3:0] hex_val;
	logic active;
	logic over_limit;
	logic size_ovf;
	logic [SIZE_BITS-1:0] chunk_dec;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	assign hex = hex_decode(item.data);
	assign is_hex = hex[4];
	assign hex_val = hex[3:0];
	assign active = (phase_q == hcbd_pkg::PH_SIZE) || (phase_q == hcbd_pkg::PH_SEEK) ||
		(phase_q == hcbd_pkg::PH_DATA) || (phase_q == hcbd_pkg::PH_TRAIL);
	assign over_limit = count_q >= body_limit;
	assign size_ovf = chunk_q[SIZE_BITS-1 -: 4] != 4'd0;
	assign chunk_dec = chunk_q - SIZE_BITS'(1);

	always_comb begin
		phase_d = phase_q;
		chunk_d = chunk_q;
		seen_cr_d = seen_cr_q;
		trail_d = trail_q;
		count_d = count_q;
		if (item.op == hcbd_pkg::OP_START) begin
			phase_d = hcbd_pkg::PH_SIZE;
			chunk_d = '0;
			seen_cr_d = 1'b0;
			trail_d = 2'd0;
			count_d = '0;
		end else if (active) begin
			if (over_limit) begin
				phase_d = hcbd_pkg::PH_FAULT;
			end else begin
				count_d = count_q + hcbd_pkg::COUNT_W'(1);
				unique case (phase_q)
					hcbd_pkg::PH_SIZE: begin
						if (is_hex) begin
							if (size_ovf) begin
								phase_d = hcbd_pkg::PH_FAULT;
							end else begin
								chunk_d = {chunk_q[SIZE_BITS-5:0], hex_val};
							end
						end else if (chunk_q == '0) begin
							phase_d = hcbd_pkg::PH_DONE;
						end else begin
							seen_cr_d = item.data == hcbd_pkg::CH_CR;
							phase_d = hcbd_pkg::PH_SEEK;
						end
					end
					hcbd_pkg::PH_SEEK: begin
						if (seen_cr_q && item.data == hcbd_pkg::CH_LF) begin
							seen_cr_d = 1'b0;
							phase_d = hcbd_pkg::PH_DATA;
						end else begin
							seen_cr_d = item.data == hcbd_pkg::CH_CR;
						end
					end
					hcbd_pkg::PH_DATA: begin
						chunk_d = chunk_dec;
						if (chunk_dec == '0) begin
							trail_d = hcbd_pkg::TRAIL_LEN;
							phase_d = hcbd_pkg::PH_TRAIL;
						end
					end
					default: begin
						trail_d = trail_q - 2'd1;
						if (trail_q == 2'd1) begin
							chunk_d = '0;
							phase_d = hcbd_pkg::PH_SIZE;
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		emit = 1'b0;
		res.kind = hcbd_pkg::KIND_BYTE;
		res.data = 8'd0;
		if (item.op == hcbd_pkg::OP_BYTE && active) begin
			if (over_limit) begin
				emit = 1'b1;
				res.kind = hcbd_pkg::KIND_ERR;
			end else begin
				unique case (phase_q)
					hcbd_pkg::PH_SIZE: begin
						if (is_hex && size_ovf) begin
							emit = 1'b1;
							res.kind = hcbd_pkg::KIND_ERR;
						end else if (!is_hex && chunk_q == '0) begin
							emit = 1'b1;
							res.kind = hcbd_pkg::KIND_END;
						end
					end
					hcbd_pkg::PH_DATA: begin
						emit = 1'b1;
						res.data = item.data;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_SIZE;
			chunk_q <= '0;
			seen_cr_q <= 1'b0;
			trail_q <= 2'd0;
			count_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			chunk_q <= chunk_d;
			seen_cr_q <= seen_cr_d;
			trail_q <= trail_d;
			count_q <= count_d;
		end
	end

endmodule

FILE: rtl/hcbd_out_reg.sv
module hcbd_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input hcbd_pkg::res_t res_in,
	output logic free,
	output logic out_valid,
	input logic out_ready,
	output hcbd_pkg::res_t res_q
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// Decodes an HTTP/1.1 chunked body one byte per request, starting right after the headers;
// a request with op set starts a new body. Payload bytes, the end of the body and errors
// (size overflow or more than body_limit raw bytes) come out as results, at most one per
// request, and bytes after the end or an error are dropped until the next start. One request
// is taken every clock cycle while no stalled result holds it; a result is offered once its
// request has moved from the input register into the result register. A stalled result holds
// the block only once the input register is also full. Reset sets body_limit to 524288.
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [hcbd_pkg::LIMIT_W-1:0] cfg_wr_data,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [7:0] byte_in,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] byte_out
);

	logic [hcbd_pkg::LIMIT_W-1:0] body_limit_q;
	hcbd_pkg::item_t item_in;
	hcbd_pkg::item_t item_s1;
	logic valid_s1;
	logic step_en;
	logic res_emit;
	logic out_free;
	hcbd_pkg::res_t res_d;
	hcbd_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limit_q <= hcbd_pkg::BODY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			body_limit_q <= cfg_wr_data;
		end
	end

	assign item_in.op = op;
	assign item_in.data = byte_in;
	assign step_en = valid_s1 && (!res_emit || out_free);

	hcbd_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.item_in(item_in),
		.take(step_en),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	hcbd_core #(
		.SIZE_BITS(SIZE_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(step_en),
		.item(item_s1),
		.body_limit(body_limit_q),
		.emit(res_emit),
		.res(res_d)
	);

	hcbd_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(step_en && res_emit),
		.res_in(res_d),
		.free(out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_q(res_q)
	);

	assign kind = res_q.kind;
	assign byte_out = res_q.data;

	a_nonbyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != hcbd_pkg::KIND_BYTE |-> byte_out == 8'd0)
		else $error("non-payload result carries a nonzero byte");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("input stalled while the input register is empty");

	a_load_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step_en && res_emit))
		else $error("result appeared without a processed request");

endmodule

FILE: test/tb.sv
module tb;

	localparam int QUIET_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [hcbd_pkg::LIMIT_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = hcbd_pkg::OP_BYTE;
	logic [7:0] byte_in = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] byte_out;

	http_chunked_body_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.byte_in(byte_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.byte_out(byte_out)
	);

	always #4 clk = ~clk;

	// Decoder state as the block should hold it.
	hcbd_pkg::phase_t ph = hcbd_pkg::PH_SIZE;
	logic [hcbd_pkg::SIZE_BITS_DEF-1:0] remain = '0;
	logic saw_cr = 1'b0;
	logic [1:0] trail_left = '0;
	logic [hcbd_pkg::COUNT_W-1:0] consumed = '0;
	logic [hcbd_pkg::LIMIT_W-1:0] limit = hcbd_pkg::BODY_LIMIT_RST;

	hcbd_pkg::res_t due_results[$];
	int errors = 0;
	int sent_items = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_request = 1'b0;
	int stall_left = 0;

	function automatic bit hex_val(input logic [7:0] c, output logic [3:0] v);
		v = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
			return 1'b1;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h41 + 8'd10);
			return 1'b1;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h61 + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic decode_step(input logic o, input logic [7:0] b);
		logic [3:0] digit;
		if (o == hcbd_pkg::OP_START) begin
			ph = hcbd_pkg::PH_SIZE;
			remain = '0;
			saw_cr = 1'b0;
			trail_left = '0;
			consumed = '0;
			return;
		end
		if (!(ph inside {hcbd_pkg::PH_SIZE, hcbd_pkg::PH_SEEK, hcbd_pkg::PH_DATA,
			hcbd_pkg::PH_TRAIL}))
			return;
		if (consumed >= limit) begin
			ph = hcbd_pkg::PH_FAULT;
			due_results.push_back({hcbd_pkg::KIND_ERR, 8'h00});
			return;
		end
		consumed = consumed + 1'b1;
		case (ph)
			hcbd_pkg::PH_SIZE: begin
				if (hex_val(b, digit)) begin
					if (remain[hcbd_pkg::SIZE_BITS_DEF-1 -: 4] != 4'h0) begin
						ph = hcbd_pkg::PH_FAULT;
						due_results.push_back({hcbd_pkg::KIND_ERR, 8'h00});
					end else begin
						remain = {remain[hcbd_pkg::SIZE_BITS_DEF-5:0], digit};
					end
				end else if (remain == '0) begin
					ph = hcbd_pkg::PH_DONE;
					due_results.push_back({hcbd_pkg::KIND_END, 8'h00});
				end else begin
					saw_cr = (b == hcbd_pkg::CH_CR);
					ph = hcbd_pkg::PH_SEEK;
				end
			end
			hcbd_pkg::PH_SEEK: begin
				if (saw_cr && b == hcbd_pkg::CH_LF) begin
					saw_cr = 1'b0;
					ph = hcbd_pkg::PH_DATA;
				end else begin
					saw_cr = (b == hcbd_pkg::CH_CR);
				end
			end
			hcbd_pkg::PH_DATA: begin
				remain = remain - 1'b1;
				if (remain == '0) begin
					trail_left = hcbd_pkg::TRAIL_LEN;
					ph = hcbd_pkg::PH_TRAIL;
				end
				due_results.push_back({hcbd_pkg::KIND_BYTE, b});
			end
			default: begin
				trail_left = trail_left - 1'b1;
				if (trail_left == '0) begin
					remain = '0;
					ph = hcbd_pkg::PH_SIZE;
				end
			end
		endcase
	endtask

	always @(posedge clk) begin
		hcbd_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				if (errors < 10)
					$display("unexpected result at %0t: kind %0d byte %02h", $time, kind, byte_out);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (kind !== want.kind || byte_out !== want.data) begin
					if (errors < 10)
						$display("mismatch at %0t: expected kind %0d byte %02h, got kind %0d byte %02h",
							$time, want.kind, want.data, kind, byte_out);
					errors++;
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			decode_step(op, byte_in);
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
			$display("FAIL http_chunked_body_decoder");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_request) begin
			stall_request = 1'b0;
			stall_left = 300;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic o, input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		op <= o;
		byte_in <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_body_limit(input logic [hcbd_pkg::LIMIT_W-1:0] v);
		drain_results();
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit = v;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(hcbd_pkg::OP_BYTE, s[i]);
	endtask

	task automatic send_crlf();
		send_item(hcbd_pkg::OP_BYTE, hcbd_pkg::CH_CR);
		send_item(hcbd_pkg::OP_BYTE, hcbd_pkg::CH_LF);
	endtask

	task automatic send_data(input int n);
		for (int i = 0; i < n; i++)
			send_item(hcbd_pkg::OP_BYTE, 8'($urandom_range(255)));
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'h30 + v;
		return (upper ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	function automatic logic [7:0] rand_nonhex();
		logic [7:0] c;
		logic [3:0] v;
		do c = 8'($urandom_range(255)); while (hex_val(c, v));
		return c;
	endfunction

	function automatic logic [7:0] rand_junk();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == hcbd_pkg::CH_CR);
		return c;
	endfunction

	// Size digits with optional leading zeros, then one of several ways of reaching CR LF.
	task automatic send_size_line(input int unsigned size);
		int nd;
		nd = 0;
		while (nd < 6 && (size >> (4 * nd)) != 0)
			nd++;
		repeat ($urandom_range(0, 2)) send_item(hcbd_pkg::OP_BYTE, 8'h30);
		for (int i = nd - 1; i >= 0; i--)
			send_item(hcbd_pkg::OP_BYTE, hex_char(4'(size >> (4 * i)), 1'($urandom_range(1))));
		case ($urandom_range(3))
			0: ;
			1: begin
				send_item(hcbd_pkg::OP_BYTE, 8'h3B);
				repeat ($urandom_range(0, 4)) send_item(hcbd_pkg::OP_BYTE, rand_junk());
			end
			2: send_item(hcbd_pkg::OP_BYTE, rand_nonhex());
			default: begin
				send_item(hcbd_pkg::OP_BYTE, hcbd_pkg::CH_CR);
				send_item(hcbd_pkg::OP_BYTE, rand_junk());
			end
		endcase
		send_crlf();
	endtask

	task automatic send_random_body();
		int chunks;
		int size;
		send_item(hcbd_pkg::OP_START, 8'($urandom_range(255)));
		chunks = $urandom_range(0, 3);
		for (int c = 0; c < chunks; c++) begin
			size = ($urandom_range(7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			send_size_line(size);
			if ($urandom_range(11) == 0) begin
				send_data($urandom_range(0, size - 1));
				return;
			end
			send_data(size);
			if ($urandom_range(5) == 0)
				send_data(2);
			else
				send_crlf();
		end
		send_size_line(0);
		if ($urandom_range(1) == 0)
			send_crlf();
	endtask

	task automatic send_overflow_body();
		send_item(hcbd_pkg::OP_START, 8'($urandom_range(255)));
		send_item(hcbd_pkg::OP_BYTE,
			hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
		repeat ($urandom_range(6, 7))
			send_item(hcbd_pkg::OP_BYTE,
				hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
		send_crlf();
	endtask

	task automatic send_noise();
		repeat ($urandom_range(5, 20))
			send_item(($urandom_range(15) == 0) ? hcbd_pkg::OP_START : hcbd_pkg::OP_BYTE,
				8'($urandom_range(255)));
	endtask

	task automatic test_directed_chunks();
		send_item(hcbd_pkg::OP_START, 8'hFF);
		send_text("2;");
		send_crlf();
		send_item(hcbd_pkg::OP_BYTE, 8'h00);
		send_item(hcbd_pkg::OP_BYTE, 8'hFF);
		send_text("zz");
		send_text("1");
		send_crlf();
		send_item(hcbd_pkg::OP_BYTE, 8'h5A);
		send_crlf();
		send_item(hcbd_pkg::OP_BYTE, hcbd_pkg::CH_CR);
		send_text("a");
	endtask

	task automatic test_size_overflow();
		send_item(hcbd_pkg::OP_START, 8'h00);
		send_text("aBcDeF0");
	endtask

	task automatic test_body_limit();
		set_body_limit(24'd3);
		send_item(hcbd_pkg::OP_START, 8'h00);
		send_text("1");
		send_crlf();
		send_item(hcbd_pkg::OP_BYTE, 8'h77);
		send_text("b");
		set_body_limit('0);
		send_item(hcbd_pkg::OP_START, 8'h00);
		send_text("0");
	endtask

	task automatic test_random_bodies(input int count, input logic [hcbd_pkg::LIMIT_W-1:0] lim);
		int target;
		set_body_limit(lim);
		target = sent_items + count;
		while (sent_items < target) begin
			case ($urandom_range(9))
				0: send_noise();
				1: send_overflow_body();
				default: send_random_body();
			endcase
		end
	endtask

	task automatic test_midstream_pause();
		send_item(hcbd_pkg::OP_START, 8'h00);
		send_text("5");
		send_crlf();
		send_data(2);
		drain_results();
		send_data(3);
		send_crlf();
		send_text("0");
		send_crlf();
	endtask

	task automatic test_output_stall();
		set_body_limit({hcbd_pkg::LIMIT_W{1'b1}});
		stall_request = 1'b1;
		repeat (3) send_random_body();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 79;
		test_directed_chunks();
		test_size_overflow();
		test_body_limit();
		test_random_bodies(230, 24'($urandom_range(20, 200)));

		send_idle_pct = 79;
		recv_idle_pct = 10;
		test_random_bodies(230, {hcbd_pkg::LIMIT_W{1'b1}});
		test_midstream_pause();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_random_bodies(220, 24'($urandom_range(30, 120)));

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("PASS http_chunked_body_decoder");
		else
			$display("FAIL http_chunked_body_decoder");
		$finish;
	end
endmodule

FILE: files.f
rtl/hcbd_pkg.sv
rtl/hcbd_in_reg.sv
rtl/hcbd_core.sv
rtl/hcbd_out_reg.sv
rtl/http_chunked_body_decoder.sv
test/tb.sv
